[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RBDF_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication
`define RBDF_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

[hw/rtl/rbdf_pkg.sv]
// ----------------------------------------------------------------------------
// rbdf_pkg
// Types, constants and the square-root step of the rounded box distance field.
// ----------------------------------------------------------------------------
`default_nettype none

package rbdf_pkg;

  localparam int unsigned FRAC_BITS = 12;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned HALF_W  = 23;
  localparam int unsigned RAD_W   = 13;
  localparam int unsigned DIST_W  = 26;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 1;
  localparam int unsigned PROD_W  = HALF_W + RAD_W;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [RAD_W-1:0]  ONE_FX   = RAD_W'(1) << FRAC_BITS;
  localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_HALF_X   = 3'd3,
    REG_HALF_Y   = 3'd4,
    REG_HALF_Z   = 3'd5,
    REG_RADIUS   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [SUM_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // one digit of the restoring square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t         o;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    cur   = {s.rem, s.n[SUM_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.n   = {s.n[SUM_W-3:0], 2'b00};
    if (cur >= trial) begin
      cur    = cur - trial;
      o.rem  = cur[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rounded_box_distance_field.sv]
// ----------------------------------------------------------------------------
// rounded_box_distance_field
// Distance from a query point to an axis-aligned box with rounded edges.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one query point per request (x, y, z, 24 bits each).
//   m_axis returns one distance per point, in order, 26-bit signed, 12 frac.
//   cfg_* writes box centre, half extents and radius; always ready. Write it
//   only while no request is in flight.
// Timing:
//   31 register stages: abs diff, shrink multiply, clamp, square, sum, then
//   25 square-root digit stages (one per stage) and the final subtract.
//   One request per cycle while the output is not stalled.
// Reset:
//   Pipeline empties; centre 0, half extents 1.0, radius 0.
// Stall:
//   While the output holds an untaken result, the whole pipeline freezes
//   and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rounded_box_distance_field (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [rbdf_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [rbdf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // points in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
  // distances out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // distance[25:0], zero[31:26]
);

  localparam int unsigned NAX      = 3;
  localparam int unsigned SQ_STEPS = rbdf_pkg::ROOT_W;
  localparam int unsigned SQ_BASE  = 5;
  localparam int unsigned NST      = SQ_BASE + SQ_STEPS + 1;
  localparam int unsigned CW       = rbdf_pkg::COORD_W;
  localparam int unsigned HW       = rbdf_pkg::HALF_W;
  localparam int unsigned RW       = rbdf_pkg::RAD_W;

  // ---------------- configuration ----------------
  logic [CW-1:0] center_q [NAX];
  logic [HW-1:0] half_q   [NAX];
  logic [RW-1:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NAX; a++) begin
        center_q[a] <= '0;
        half_q[a]   <= rbdf_pkg::HALF_RST;
      end
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      case (rbdf_pkg::cfg_reg_e'(cfg_addr_i))
        rbdf_pkg::REG_CENTER_X: center_q[0] <= cfg_data_i[CW-1:0];
        rbdf_pkg::REG_CENTER_Y: center_q[1] <= cfg_data_i[CW-1:0];
        rbdf_pkg::REG_CENTER_Z: center_q[2] <= cfg_data_i[CW-1:0];
        rbdf_pkg::REG_HALF_X:   half_q[0]   <= cfg_data_i[HW-1:0];
        rbdf_pkg::REG_HALF_Y:   half_q[1]   <= cfg_data_i[HW-1:0];
        rbdf_pkg::REG_HALF_Z:   half_q[2]   <= cfg_data_i[HW-1:0];
        rbdf_pkg::REG_RADIUS:   radius_q    <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NST-1:0] v_q;
  logic           adv;

  assign adv           = ~v_q[NST-1] | m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: |p - c|, radius ----------------
  logic [CW-1:0] d1_d [NAX];
  logic [CW-1:0] d1_q [NAX];
  logic [RW-1:0] r1_d, r1_q, om1_d, om1_q;

  always_comb begin
    logic [CW:0] diff;
    for (int a = 0; a < NAX; a++) begin
      diff    = {s_axis_tdata[a*CW + CW-1], s_axis_tdata[a*CW +: CW]}
              - {center_q[a][CW-1], center_q[a]};
      d1_d[a] = diff[CW] ? CW'(-diff) : diff[CW-1:0];
    end
    r1_d  = (radius_q > rbdf_pkg::ONE_FX) ? rbdf_pkg::ONE_FX : radius_q;
    om1_d = rbdf_pkg::ONE_FX - r1_d;
  end

  // ---------------- stage 2: shrunk half extent ----------------
  logic [HW-1:0] s2_d [NAX];
  logic [HW-1:0] s2_q [NAX];
  logic [CW-1:0] d2_q [NAX];
  logic [RW-1:0] r2_q;

  always_comb begin
    logic [rbdf_pkg::PROD_W-1:0] prod;
    for (int a = 0; a < NAX; a++) begin
      prod    = half_q[a] * om1_q;
      s2_d[a] = prod[rbdf_pkg::FRAC_BITS +: HW];
    end
  end

  // ---------------- stage 3: clamped excess ----------------
  logic [CW-1:0] e3_d [NAX];
  logic [CW-1:0] e3_q [NAX];
  logic [RW-1:0] r3_q;

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      e3_d[a] = (d2_q[a] > {1'b0, s2_q[a]}) ? (d2_q[a] - {1'b0, s2_q[a]}) : '0;
    end
  end

  // ---------------- stage 4: squares, stage 5: sum ----------------
  logic [rbdf_pkg::SQ_W-1:0]  sq4_q [NAX];
  logic [RW-1:0]              r4_q, r5_q;
  logic [rbdf_pkg::SUM_W-1:0] sum5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NAX; a++) begin
        d1_q[a]  <= d1_d[a];
        s2_q[a]  <= s2_d[a];
        d2_q[a]  <= d1_q[a];
        e3_q[a]  <= e3_d[a];
        sq4_q[a] <= e3_q[a] * e3_q[a];
      end
      r1_q   <= r1_d;
      om1_q  <= om1_d;
      r2_q   <= r1_q;
      r3_q   <= r2_q;
      r4_q   <= r3_q;
      sum5_q <= rbdf_pkg::SUM_W'(sq4_q[0]) + rbdf_pkg::SUM_W'(sq4_q[1])
              + rbdf_pkg::SUM_W'(sq4_q[2]);
      r5_q   <= r4_q;
    end
  end

  // ---------------- square root, one digit per stage ----------------
  rbdf_pkg::sqrt_st_t sq_q [SQ_STEPS];
  logic [RW-1:0]      sr_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    rbdf_pkg::sqrt_st_t in_st;
    logic [RW-1:0]      in_r;
    if (k == 0) begin : g_first
      assign in_st = '{n: sum5_q, rem: '0, root: '0};
      assign in_r  = r5_q;
    end else begin : g_next
      assign in_st = sq_q[k-1];
      assign in_r  = sr_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k] <= rbdf_pkg::sqrt_step(in_st);
        sr_q[k] <= in_r;
      end
    end
  end

  // ---------------- output: root minus radius ----------------
  logic [rbdf_pkg::DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= rbdf_pkg::DIST_W'(sq_q[SQ_STEPS-1].root)
              - rbdf_pkg::DIST_W'(sr_q[SQ_STEPS-1]);
    end
  end

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tdata  = {{(32-rbdf_pkg::DIST_W){1'b0}}, dist_q};

  // ---------------- assertions ----------------
  `RBDF_ASSERT_NXT(a_enter, s_axis_tvalid && s_axis_tready, v_q[0])
  `RBDF_ASSERT_NXT(a_freeze, !adv, $stable(v_q))
  `RBDF_ASSERT_IMP(a_root_rem, v_q[SQ_BASE+SQ_STEPS-1],
    {1'b0, sq_q[SQ_STEPS-1].rem} <= {sq_q[SQ_STEPS-1].root, 1'b0})
  `RBDF_ASSERT_IMP(a_dist_floor, m_axis_tvalid,
    $signed(dist_q) >= -$signed({1'b0, rbdf_pkg::ONE_FX}))

endmodule

`default_nettype wire
